// ----- rtl/core/ipr_pkg.sv -----
// ipr_pkg: shared types and constants for the ir pulse record/replay unit
// no dependencies; imported by every module of the block
`default_nettype none

package ipr_pkg;

    localparam int DUR_W     = 9;   // duration, run limit and idle gap width
    localparam int IDX_OUT_W = 6;   // width of the reported store index
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GAP  = 1'b1;

    localparam logic [DUR_W-1:0] RUN_LIMIT_RST = 9'd300;
    localparam logic [DUR_W-1:0] IDLE_GAP_RST  = 9'd70;

    // capture results for one tick, after the tick
    typedef struct packed {
        logic             capturing;
        logic             stored;
        logic [DUR_W-1:0] duration;
    } t_cap_status;

endpackage

`default_nettype wire

// ----- rtl/core/ipr_dur_store.sv -----
// ipr_dur_store: duration memory with registered, write-forwarded read port
// entries not yet written since reset read as zero via the fill position
// depends on ipr_pkg
`default_nettype none

module ipr_dur_store #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [ipr_pkg::DUR_W-1:0]  i_wdata,
    input  logic [AW-1:0]              i_raddr,
    input  logic [AW-1:0]              i_fill_idx,
    input  logic                       i_fill_wrapped,
    output logic [ipr_pkg::DUR_W-1:0]  o_rdata
);
    import ipr_pkg::*;

    logic [DUR_W-1:0] r_mem [DEPTH];
    logic [DUR_W-1:0] r_rdata;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data follows a write to the same entry in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // entry holds data once the sequential write pointer has passed it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_fill_wrapped || (i_raddr < i_fill_idx);
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

`default_nettype wire

// ----- rtl/core/ipr_capture.sv -----
// ipr_capture: receive-side run counter, capture gate and store write pointer
// depends on ipr_pkg
`default_nettype none

module ipr_capture #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_ir,
    input  logic [ipr_pkg::DUR_W-1:0]  i_run_limit,
    input  logic [ipr_pkg::DUR_W-1:0]  i_idle_gap,
    output ipr_pkg::t_cap_status       o_status,
    output logic [AW-1:0]              o_waddr,
    output logic [AW-1:0]              o_fill_idx,
    output logic                       o_fill_wrapped
);
    import ipr_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic             r_cap, n_cap;
    logic             r_mark, n_mark;
    logic [DUR_W-1:0] r_cnt, n_cnt;
    logic [AW-1:0]    r_widx, n_widx;
    logic             r_wrapped, n_wrapped;
    logic             cap_gate;
    logic             mark_gate;
    logic [DUR_W-1:0] cnt_gate;
    logic             continues;
    logic             store;

    always_comb begin
        cap_gate  = r_cap;
        mark_gate = r_mark;
        cnt_gate  = r_cnt;
        // start of a capture
        if (i_ir && !r_cap) begin
            cap_gate  = 1'b1;
            mark_gate = 1'b1;
            cnt_gate  = '0;
        end
        // long space ends it
        if (!mark_gate && (cnt_gate == i_idle_gap)) begin
            cap_gate = 1'b0;
        end

        n_cap     = cap_gate;
        n_mark    = mark_gate;
        n_cnt     = cnt_gate;
        n_widx    = r_widx;
        n_wrapped = r_wrapped;
        store     = 1'b0;
        continues = mark_gate ? i_ir : !i_ir;
        if (cap_gate) begin
            if (continues && (cnt_gate < i_run_limit)) begin
                n_cnt = cnt_gate + 9'd1;
            end else begin
                store     = 1'b1;
                n_cnt     = 9'd1;
                n_mark    = !mark_gate;
                n_widx    = (r_widx == LAST_IDX) ? '0 : r_widx + 1'b1;
                n_wrapped = r_wrapped || (r_widx == LAST_IDX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= 1'b0;
            r_mark    <= 1'b1;
            r_cnt     <= '0;
            r_widx    <= '0;
            r_wrapped <= 1'b0;
        end else if (i_step) begin
            r_cap     <= n_cap;
            r_mark    <= n_mark;
            r_cnt     <= n_cnt;
            r_widx    <= n_widx;
            r_wrapped <= n_wrapped;
        end
    end

    assign o_status.capturing = i_step ? n_cap : r_cap;
    assign o_status.stored    = i_step && store;
    assign o_status.duration  = (i_step && store) ? cnt_gate : '0;
    assign o_waddr            = r_widx;
    assign o_fill_idx         = i_step ? n_widx : r_widx;
    assign o_fill_wrapped     = i_step ? n_wrapped : r_wrapped;

endmodule

`default_nettype wire

// ----- rtl/core/ipr_replay.sv -----
// ipr_replay: transmit-side replay sequencer stepping through stored durations
// depends on ipr_pkg
`default_nettype none

module ipr_replay #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [ipr_pkg::DUR_W-1:0]  i_entry,
    output logic                       o_drive,
    output logic [AW-1:0]              o_rd_addr
);
    import ipr_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0]    r_idx, n_idx;
    logic [DUR_W-1:0] r_time, n_time;
    logic             r_level, n_level;
    logic             r_drive, n_drive;

    always_comb begin
        n_idx   = r_idx;
        n_time  = r_time;
        n_level = r_level;
        n_drive = r_drive;
        if (i_step) begin
            if (r_time < i_entry) begin
                n_drive = r_level;
                n_time  = r_time + 9'd1;
            end else begin
                n_level = !r_level;
                n_idx   = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                n_time  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_time  <= '0;
            r_level <= 1'b1;
            r_drive <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_time  <= n_time;
            r_level <= n_level;
            r_drive <= n_drive;
        end
    end

    assign o_drive   = n_drive;
    // fetch the entry for the next tick
    assign o_rd_addr = n_idx;

endmodule

`default_nettype wire

// ----- rtl/core/ir_pulse_record_replay_unit.sv -----
// ir_pulse_record_replay_unit: top level of the ir pulse record/replay block
// depends on ipr_pkg, ipr_dur_store, ipr_capture, ipr_replay
//
// usage:
//   one input transaction per timer tick carries ir_active and toggle_mode;
//   each one produces exactly one result transaction (drive level, mode,
//   capture flag and the store write of that tick, if any).
//   both channels use valid/stall; a transaction moves when valid is high
//   and stall is low. configuration (run_limit, idle_gap) is written through
//   i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle.
// output register and throughput:
//   the result appears in the output register in the cycle after the input is
//   taken; a new tick is taken every cycle unless a held result is stalled
//   in the single result register; the duration memory read is registered.
// stall:
//   while the receiver stalls and a result is held, o_in_stall is high;
//   once the result is taken, a new tick is taken in the same cycle.
// reset:
//   synchronous, active low; receive mode, no capture, registers back to
//   300 and 70, the duration store reads as all zeros until written.
`default_nettype none

module ir_pulse_record_replay_unit #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [ipr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ipr_pkg::DUR_W-1:0]     i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_ir_active,
    input  logic                          i_toggle_mode,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_tx_level,
    output logic                          o_transmit_mode,
    output logic                          o_capture_active,
    output logic                          o_store_valid,
    output logic [ipr_pkg::DUR_W-1:0]     o_stored_duration,
    output logic [ipr_pkg::IDX_OUT_W-1:0] o_stored_index
);
    import ipr_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int SW = (AW > IDX_OUT_W) ? AW : IDX_OUT_W;

    logic [DUR_W-1:0]     r_run_limit;
    logic [DUR_W-1:0]     r_idle_gap;
    logic                 r_mode;
    logic                 n_mode;
    logic                 accept;
    logic                 cap_step;
    logic                 rep_step;
    t_cap_status          cap_status;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        fill_idx;
    logic                 fill_wrapped;
    logic [AW-1:0]        rd_addr;
    logic [DUR_W-1:0]     entry;
    logic                 drive;
    logic [SW-1:0]        widx_wide;

    logic                 r_out_valid;
    logic                 r_tx_level;
    logic                 r_transmit_mode;
    logic                 r_capture_active;
    logic                 r_store_valid;
    logic [DUR_W-1:0]     r_stored_duration;
    logic [IDX_OUT_W-1:0] r_stored_index;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_limit <= RUN_LIMIT_RST;
            r_idle_gap  <= IDLE_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RUN_LIMIT: r_run_limit <= i_cfg_data;
                CFG_IDLE_GAP:  r_idle_gap  <= i_cfg_data;
            endcase
        end
    end

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_mode     = r_mode ^ i_toggle_mode;
    assign cap_step   = accept && !n_mode;
    assign rep_step   = accept && n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

    ipr_capture #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_capture (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (cap_step),
        .i_ir           (i_ir_active),
        .i_run_limit    (r_run_limit),
        .i_idle_gap     (r_idle_gap),
        .o_status       (cap_status),
        .o_waddr        (waddr),
        .o_fill_idx     (fill_idx),
        .o_fill_wrapped (fill_wrapped)
    );

    ipr_dur_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_we           (cap_status.stored),
        .i_waddr        (waddr),
        .i_wdata        (cap_status.duration),
        .i_raddr        (rd_addr),
        .i_fill_idx     (fill_idx),
        .i_fill_wrapped (fill_wrapped),
        .o_rdata        (entry)
    );

    ipr_replay #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_replay (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (rep_step),
        .i_entry   (entry),
        .o_drive   (drive),
        .o_rd_addr (rd_addr)
    );

    // reported index is the low bits of the entry number
    assign widx_wide = SW'(waddr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx_level        <= drive;
            r_transmit_mode   <= n_mode;
            r_capture_active  <= cap_status.capturing;
            r_store_valid     <= cap_status.stored;
            r_stored_duration <= cap_status.duration;
            r_stored_index    <= cap_status.stored ? widx_wide[IDX_OUT_W-1:0] : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_tx_level        = r_tx_level;
    assign o_transmit_mode   = r_transmit_mode;
    assign o_capture_active  = r_capture_active;
    assign o_store_valid     = r_store_valid;
    assign o_stored_duration = r_stored_duration;
    assign o_stored_index    = r_stored_index;

`ifndef SYNTHESIS
    // the store is only written in receive mode
    a_store_rx_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_store_valid |-> !o_transmit_mode)
        else $error("store write reported in transmit mode");

    // no write means zero duration and index
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_store_valid |-> (o_stored_duration == '0) && (o_stored_index == '0))
        else $error("duration or index set without a store write");

    // input side only held back by a waiting result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with an empty result register");

    // every accepted tick yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted transaction produced no result");
`endif

endmodule

`default_nettype wire

// ----- sim/ipr_tick_checker.sv -----
// ipr_tick_checker: watches the tick and result channels of the ir pulse
// record/replay unit, predicts each result and compares it field by field
// depends on ipr_pkg
`timescale 1ns / 100ps

module ipr_tick_checker #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ipr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ipr_pkg::DUR_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_ir_active,
    input  logic                          i_toggle_mode,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_tx_level,
    input  logic                          i_transmit_mode,
    input  logic                          i_capture_active,
    input  logic                          i_store_valid,
    input  logic [ipr_pkg::DUR_W-1:0]     i_stored_duration,
    input  logic [ipr_pkg::IDX_OUT_W-1:0] i_stored_index,
    output int                            o_pending,
    output int                            o_mismatches,
    output int                            o_results
);
    import ipr_pkg::*;

    typedef struct packed {
        logic                 tx_level;
        logic                 transmit_mode;
        logic                 capture_active;
        logic                 store_valid;
        logic [DUR_W-1:0]     duration;
        logic [IDX_OUT_W-1:0] index;
    } t_tick_result;

    logic [DUR_W-1:0] run_limit;
    logic [DUR_W-1:0] idle_gap;
    logic             mode_bit;
    logic             capturing;
    logic             mark_phase;
    logic [DUR_W-1:0] run_count;
    int               write_index;
    logic [DUR_W-1:0] durations [STORE_DEPTH];
    int               replay_index;
    logic [DUR_W-1:0] replay_time;
    logic             replay_level;
    logic             drive_level;

    t_tick_result     tick_results_q[$];
    int               fail_count = 0;
    int               result_count = 0;

    assign o_mismatches = fail_count;
    assign o_results    = result_count;

    // advances the capture/replay state by one timer tick
    function automatic t_tick_result advance_tick(logic ir, logic tog);
        t_tick_result r;
        logic         continues;
        r = '0;
        if (tog) begin
            mode_bit = ~mode_bit;
        end
        if (!mode_bit) begin
            if (ir && !capturing) begin
                run_count  = '0;
                mark_phase = 1'b1;
                capturing  = 1'b1;
            end
            if (!mark_phase && run_count == idle_gap) begin
                capturing = 1'b0;
            end
            if (capturing) begin
                continues = mark_phase ? ir : ~ir;
                if (continues && run_count < run_limit) begin
                    run_count = run_count + 1'b1;
                end else begin
                    durations[write_index] = run_count;
                    r.store_valid = 1'b1;
                    r.duration    = run_count;
                    r.index       = write_index[IDX_OUT_W-1:0];
                    write_index   = (write_index + 1) % STORE_DEPTH;
                    run_count     = DUR_W'(1);
                    mark_phase    = ~mark_phase;
                end
            end
        end else begin
            // capture frozen, replay one step
            if (replay_time < durations[replay_index]) begin
                drive_level = replay_level;
                replay_time = replay_time + 1'b1;
            end else begin
                replay_level = ~replay_level;
                replay_index = (replay_index + 1) % STORE_DEPTH;
                replay_time  = '0;
            end
        end
        r.tx_level       = drive_level;
        r.transmit_mode  = mode_bit;
        r.capture_active = capturing;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tick_result want;
        if (!i_rst_n) begin
            run_limit    = RUN_LIMIT_RST;
            idle_gap     = IDLE_GAP_RST;
            mode_bit     = 1'b0;
            capturing    = 1'b0;
            mark_phase   = 1'b1;
            run_count    = '0;
            write_index  = 0;
            replay_index = 0;
            replay_time  = '0;
            replay_level = 1'b1;
            drive_level  = 1'b0;
            for (int k = 0; k < STORE_DEPTH; k++) begin
                durations[k] = '0;
            end
            tick_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RUN_LIMIT) begin
                    run_limit = i_cfg_data;
                end else if (i_cfg_idx == CFG_IDLE_GAP) begin
                    idle_gap = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                tick_results_q.push_back(advance_tick(i_ir_active, i_toggle_mode));
            end
            if (i_out_valid && !i_out_stall) begin
                result_count++;
                if (tick_results_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    want = tick_results_q.pop_front();
                    check_field("tx_level", want.tx_level, i_tx_level);
                    check_field("transmit_mode", want.transmit_mode, i_transmit_mode);
                    check_field("capture_active", want.capture_active, i_capture_active);
                    check_field("store_valid", want.store_valid, i_store_valid);
                    check_field("stored_duration", want.duration, i_stored_duration);
                    check_field("stored_index", want.index, i_stored_index);
                end
            end
        end
        o_pending <= tick_results_q.size();
    end

endmodule

// ----- sim/ir_pulse_record_replay_unit_tb.sv -----
// ir_pulse_record_replay_unit_tb: drives timer ticks and register settings
// into the record/replay unit; checking is done by ipr_tick_checker
// depends on ipr_pkg, ipr_tick_checker and the unit itself
`timescale 1ns / 100ps

module ir_pulse_record_replay_unit_tb;
    import ipr_pkg::*;

    localparam int STORE_DEPTH    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_WAIT       = 8;
    localparam int PHASE_TICKS    = 120;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DUR_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 ir_active;
    logic                 toggle_mode;
    logic                 out_valid;
    logic                 out_stall;
    logic                 tx_level;
    logic                 transmit_mode;
    logic                 capture_active;
    logic                 store_valid;
    logic [DUR_W-1:0]     stored_duration;
    logic [IDX_OUT_W-1:0] stored_index;

    int               pending;
    int               mismatches;
    int               results_checked;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               ticks_sent;
    int               settings_used;
    int               quiet_cycles;
    logic             tb_mode;
    logic [DUR_W-1:0] cur_limit;
    logic [DUR_W-1:0] cur_gap;

    ir_pulse_record_replay_unit #(
        .STORE_DEPTH (STORE_DEPTH)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_ir_active       (ir_active),
        .i_toggle_mode     (toggle_mode),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_tx_level        (tx_level),
        .o_transmit_mode   (transmit_mode),
        .o_capture_active  (capture_active),
        .o_store_valid     (store_valid),
        .o_stored_duration (stored_duration),
        .o_stored_index    (stored_index)
    );

    ipr_tick_checker #(
        .STORE_DEPTH (STORE_DEPTH)
    ) checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_ir_active       (ir_active),
        .i_toggle_mode     (toggle_mode),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_tx_level        (tx_level),
        .i_transmit_mode   (transmit_mode),
        .i_capture_active  (capture_active),
        .i_store_valid     (store_valid),
        .i_stored_duration (stored_duration),
        .i_stored_index    (stored_index),
        .o_pending         (pending),
        .o_mismatches      (mismatches),
        .o_results         (results_checked)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ends the run if nothing moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("ir_pulse_record_replay_unit_tb: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // one timer tick, held until the unit takes it
    task automatic send_tick(input logic ir, input logic tog);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        ir_active   <= ir;
        toggle_mode <= tog;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        ticks_sent++;
        tb_mode ^= tog;
    endtask

    task automatic send_run(input logic ir, input int n);
        repeat (n) send_tick(ir, 1'b0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (END_WAIT) @(posedge clk);
    endtask

    task automatic write_settings(input logic [DUR_W-1:0] run_lim,
                                  input logic [DUR_W-1:0] gap);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_RUN_LIMIT;
        cfg_data <= run_lim;
        @(posedge clk);
        cfg_idx  <= CFG_IDLE_GAP;
        cfg_data <= gap;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_limit = run_lim;
        cur_gap   = gap;
        settings_used++;
    endtask

    task automatic replay_ticks(input int n);
        repeat (n) send_tick(1'($urandom_range(1)), 1'b0);
    endtask

    // alternating marks and spaces, a space past idle gaps <= 80, maybe a replay
    task automatic send_frame();
        int runs;
        int cap;
        int gap_len;
        cap = (cur_limit > 40 && $urandom_range(9) != 0) ? 40 : cur_limit + 2;
        if (tb_mode) begin
            send_tick(1'($urandom_range(1)), 1'b1);
        end
        runs = $urandom_range(8, 1);
        for (int i = 0; i < runs; i++) begin
            send_run(i % 2 == 0, $urandom_range(cap, 1));
        end
        gap_len = (cur_gap > 80 && $urandom_range(3) != 0) ? 80 : cur_gap;
        send_run(1'b0, gap_len + $urandom_range(3, 1));
        if ($urandom_range(1)) begin
            send_tick(1'($urandom_range(1)), 1'b1);
            replay_ticks($urandom_range(60, 5));
        end
    endtask

    // capture cut short by leaving receive mode, resumed on return
    task automatic send_broken_frame();
        if (tb_mode) begin
            send_tick(1'b1, 1'b1);
        end
        send_run(1'b1, $urandom_range(12, 1));
        send_run(1'b0, $urandom_range(5, 1));
        send_tick(1'($urandom_range(1)), 1'b1);
        replay_ticks($urandom_range(20, 1));
        send_tick(1'($urandom_range(1)), 1'b1);
        send_run(1'($urandom_range(1)), $urandom_range(10, 1));
    endtask

    task automatic run_phase(input logic [DUR_W-1:0] run_lim, input logic [DUR_W-1:0] gap,
                             input int idle_pct, input int stall_pct);
        int stop;
        int pick;
        write_settings(run_lim, gap);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop = ticks_sent + PHASE_TICKS;
        while (ticks_sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame();
            end else if (pick < 85) begin
                repeat ($urandom_range(10, 1)) begin
                    send_tick(1'($urandom_range(1)), $urandom_range(3) == 0);
                end
            end else begin
                send_broken_frame();
            end
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_RUN_LIMIT;
        cfg_data       = '0;
        in_valid       = 1'b0;
        ir_active      = 1'b0;
        toggle_mode    = 1'b0;
        send_idle_pct  = 17;
        recv_stall_pct = 83;
        ticks_sent     = 0;
        settings_used  = 0;
        tb_mode        = 1'b0;
        cur_limit      = RUN_LIMIT_RST;
        cur_gap        = IDLE_GAP_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // short limits so every case shows in a handful of ticks
        write_settings(9'd2, 9'd2);
        send_tick(1'b0, 1'b0);
        send_run(1'b1, 3);            // mark cut at the run limit
        send_run(1'b0, 2);            // space reaches the idle gap
        send_tick(1'b0, 1'b1);        // into transmit
        send_run(1'b0, 2);
        send_tick(1'b1, 1'b0);        // zero-length entry flips straight on
        send_tick(1'b1, 1'b1);        // back to receive, capture starts
        send_tick(1'b1, 1'b1);        // toggle held
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);

        // zero limit stores every tick, zero gap never ends the capture
        write_settings(9'd0, 9'd0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);

        run_phase(9'd5,   9'd3,   17, 83);
        run_phase(9'd1,   9'd1,   17, 83);
        run_phase(9'd20,  9'd40,  17, 83);
        run_phase(9'd12,  9'd8,   83, 17);
        run_phase(9'd300, 9'd70,  83, 17);
        run_phase(9'd7,   9'd0,   83, 17);
        run_phase(9'd511, 9'd511, 0,  0);
        run_phase(9'd30,  9'd15,  0,  0);

        settle();
        $display("covered %0d ticks under %0d register settings, %0d results checked",
                 ticks_sent, settings_used, results_checked);
        if (mismatches == 0) begin
            $display("ir_pulse_record_replay_unit_tb: PASS");
        end else begin
            $display("ir_pulse_record_replay_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ipr_pkg.sv
rtl/core/ipr_dur_store.sv
rtl/core/ipr_capture.sv
rtl/core/ipr_replay.sv
rtl/core/ir_pulse_record_replay_unit.sv
sim/ipr_tick_checker.sv
sim/ir_pulse_record_replay_unit_tb.sv
